FILE: rtl/core/mi3_pkg.sv
// Shared types and widths of the 3x3 matrix inverse pipeline.
package mi3_pkg;

  localparam int unsigned EW = 32;  // matrix and inverse entry width
  localparam int unsigned CW = 64;  // exact cofactor width
  localparam int unsigned DW = 98;  // exact signed determinant width
  localparam int unsigned MW = 97;  // determinant magnitude width
  localparam int unsigned QB = 33;  // quotient bits developed by the divider

  localparam logic [QB-1:0] LIM_POS = QB'(64'h7FFF_FFFF);
  localparam logic [QB-1:0] LIM_NEG = QB'(64'h8000_0000);

  typedef struct packed {
    logic signed [EW-1:0] a00;
    logic signed [EW-1:0] a01;
    logic signed [EW-1:0] a02;
    logic signed [EW-1:0] a10;
    logic signed [EW-1:0] a11;
    logic signed [EW-1:0] a12;
    logic signed [EW-1:0] a20;
    logic signed [EW-1:0] a21;
    logic signed [EW-1:0] a22;
  } in_t;

  typedef struct packed {
    logic signed [EW-1:0] inv00;
    logic signed [EW-1:0] inv01;
    logic signed [EW-1:0] inv02;
    logic signed [EW-1:0] inv10;
    logic signed [EW-1:0] inv11;
    logic signed [EW-1:0] inv12;
    logic signed [EW-1:0] inv20;
    logic signed [EW-1:0] inv21;
    logic signed [EW-1:0] inv22;
    logic                 singular;
    logic                 overflow;
  } out_t;

endpackage

FILE: rtl/core/mi3_if.sv
// Valid/ready channel interfaces for matrix input and inverse output.
interface mi3_in_if
  import mi3_pkg::*;
();
  logic valid;
  logic ready;
  in_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mi3_out_if
  import mi3_pkg::*;
();
  logic valid;
  logic ready;
  out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/mi3_cof.sv
// Cofactor stages: eighteen products, then nine exact differences.
module mi3_cof
  import mi3_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  in_t                  mat_i,
  output logic                 vld_o,
  output logic signed [EW-1:0] row0_o [3],
  output logic signed [CW-1:0] cof_o [9]
);

  logic signed [EW-1:0] am [9];
  logic signed [CW-1:0] p_d [18];
  logic signed [CW-1:0] p_q [18];
  logic signed [EW-1:0] row_p_q [3];
  logic signed [CW-1:0] cof_d [9];
  logic signed [CW-1:0] cof_q [9];
  logic signed [EW-1:0] row_q [3];
  logic                 vld1_q, vld2_q;

  assign am[0] = mat_i.a00;
  assign am[1] = mat_i.a01;
  assign am[2] = mat_i.a02;
  assign am[3] = mat_i.a10;
  assign am[4] = mat_i.a11;
  assign am[5] = mat_i.a12;
  assign am[6] = mat_i.a20;
  assign am[7] = mat_i.a21;
  assign am[8] = mat_i.a22;

  // even product minus odd product gives each cofactor
  always_comb begin
    p_d[0]  = am[4] * am[8];
    p_d[1]  = am[7] * am[5];
    p_d[2]  = am[2] * am[7];
    p_d[3]  = am[1] * am[8];
    p_d[4]  = am[1] * am[5];
    p_d[5]  = am[2] * am[4];
    p_d[6]  = am[5] * am[6];
    p_d[7]  = am[3] * am[8];
    p_d[8]  = am[0] * am[8];
    p_d[9]  = am[2] * am[6];
    p_d[10] = am[3] * am[2];
    p_d[11] = am[0] * am[5];
    p_d[12] = am[3] * am[7];
    p_d[13] = am[6] * am[4];
    p_d[14] = am[6] * am[1];
    p_d[15] = am[0] * am[7];
    p_d[16] = am[0] * am[4];
    p_d[17] = am[3] * am[1];
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      cof_d[k] = p_q[2*k] - p_q[2*k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q     <= p_d;
      row_p_q <= am[0:2];
      cof_q   <= cof_d;
      row_q   <= row_p_q;
    end
  end

  assign vld_o  = vld2_q;
  assign row0_o = row_q;
  assign cof_o  = cof_q;

endmodule

FILE: rtl/core/mi3_det.sv
// Determinant stages: split products, term assembly, three-way sum.
module mi3_det
  import mi3_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic signed [EW-1:0] row0_i [3],
  input  logic signed [CW-1:0] cof_i [9],
  output logic                 vld_o,
  output logic signed [DW-1:0] det_o,
  output logic signed [CW-1:0] cof_o [9]
);

  localparam int unsigned TW = EW + CW;

  logic signed [CW:0]   pl_d [3];
  logic signed [CW:0]   pl_q [3];
  logic signed [CW-1:0] ph_d [3];
  logic signed [CW-1:0] ph_q [3];
  logic signed [TW-1:0] term_d [3];
  logic signed [TW-1:0] term_q [3];
  logic signed [DW-1:0] det_d, det_q;
  logic signed [CW-1:0] c1_q [9], c2_q [9], c3_q [9];
  logic [2:0]           vld_q;

  // entry times low (unsigned) and high (signed) half of its cofactor
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      pl_d[j] = row0_i[j] * $signed({1'b0, cof_i[3*j][EW-1:0]});
      ph_d[j] = row0_i[j] * $signed(cof_i[3*j][CW-1:EW]);
    end
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      term_d[j] = {ph_q[j], {EW{1'b0}}} + TW'(pl_q[j]);
    end
  end

  assign det_d = DW'(term_q[0]) + DW'(term_q[1]) + DW'(term_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q   <= pl_d;
      ph_q   <= ph_d;
      c1_q   <= cof_i;
      term_q <= term_d;
      c2_q   <= c1_q;
      det_q  <= det_d;
      c3_q   <= c2_q;
    end
  end

  assign vld_o = vld_q[2];
  assign det_o = det_q;
  assign cof_o = c3_q;

endmodule

FILE: rtl/core/mi3_div.sv
// Nine-lane pipelined restoring divider with saturation and sign fix-up.
module mi3_div
  import mi3_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 vld_i,
  input  logic signed [DW-1:0] det_i,
  input  logic signed [CW-1:0] cof_i [9],
  output logic                 vld_o,
  output out_t                 res_o
);

  localparam int unsigned NW = CW + 2 * FRAC_BITS;
  localparam int unsigned HW = NW - QB;
  localparam int unsigned XW = (HW > MW) ? HW : MW;

  // magnitude stage
  logic [DW-1:0] det_abs;
  logic [CW-1:0] cmag_d [9];
  logic [8:0]    neg_d;
  logic          vld_p_q, sing_p_q;
  logic [MW-1:0] dmag_p_q;
  logic [CW-1:0] cmag_p_q [9];
  logic [8:0]    neg_p_q;

  // division stages, index 0 is the range check
  logic          vld_q  [QB+1];
  logic          sing_q [QB+1];
  logic [MW-1:0] dmag_q [QB+1];
  logic [8:0]    neg_q  [QB+1];
  logic [8:0]    sat_q  [QB+1];
  logic [MW-1:0] r_q    [QB+1][9];
  logic [QB-1:0] lo_q   [QB+1][9];
  logic [QB-1:0] q_q    [QB+1][9];

  logic [MW-1:0] r0_d  [9];
  logic [QB-1:0] lo0_d [9];
  logic [8:0]    sat0_d;

  logic signed [EW-1:0] inv [9];
  logic [8:0]           ovf;

  assign det_abs = det_i[DW-1] ? DW'(-det_i) : DW'(det_i);

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      cmag_d[k] = cof_i[k][CW-1] ? CW'(-cof_i[k]) : CW'(cof_i[k]);
      neg_d[k]  = cof_i[k][CW-1] ^ det_i[DW-1];
    end
  end

  // quotient fits in QB bits only when the numerator's top part is below the divisor;
  // that top part is then the running remainder
  always_comb begin
    logic [NW-1:0] num;
    for (int k = 0; k < 9; k++) begin
      num       = {cmag_p_q[k], {(2 * FRAC_BITS){1'b0}}};
      sat0_d[k] = XW'(num[NW-1:QB]) >= XW'(dmag_p_q);
      r0_d[k]   = MW'(num[NW-1:QB]);
      lo0_d[k]  = num[QB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_p_q  <= 1'b0;
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_p_q  <= vld_i;
      vld_q[0] <= vld_p_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sing_p_q  <= (det_i == '0);
      dmag_p_q  <= det_abs[MW-1:0];
      cmag_p_q  <= cmag_d;
      neg_p_q   <= neg_d;
      sing_q[0] <= sing_p_q;
      dmag_q[0] <= dmag_p_q;
      neg_q[0]  <= neg_p_q;
      sat_q[0]  <= sat0_d;
      r_q[0]    <= r0_d;
      lo_q[0]   <= lo0_d;
      q_q[0]    <= '{default: '0};
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_stage
    logic [MW-1:0] r_d [9];
    logic [QB-1:0] q_d [9];

    always_comb begin
      logic [MW:0] rs;
      logic [MW:0] diff;
      logic        ge;
      for (int k = 0; k < 9; k++) begin
        rs     = {r_q[s-1][k], lo_q[s-1][k][QB-s]};
        diff   = rs - {1'b0, dmag_q[s-1]};
        ge     = rs >= {1'b0, dmag_q[s-1]};
        r_d[k] = ge ? diff[MW-1:0] : rs[MW-1:0];
        q_d[k] = {q_q[s-1][k][QB-2:0], ge};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sing_q[s] <= sing_q[s-1];
        dmag_q[s] <= dmag_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        sat_q[s]  <= sat_q[s-1];
        lo_q[s]   <= lo_q[s-1];
        r_q[s]    <= r_d;
        q_q[s]    <= q_d;
      end
    end
  end

  // clamp to the signed range, restore the sign, zero everything when singular
  always_comb begin
    logic [QB-1:0] lim;
    logic [QB-1:0] m;
    logic [QB-1:0] v;
    for (int k = 0; k < 9; k++) begin
      lim    = neg_q[QB][k] ? LIM_NEG : LIM_POS;
      ovf[k] = sat_q[QB][k] || (q_q[QB][k] > lim);
      m      = ovf[k] ? lim : q_q[QB][k];
      v      = neg_q[QB][k] ? QB'(-m) : m;
      inv[k] = sing_q[QB] ? '0 : $signed(v[EW-1:0]);
    end
  end

  always_comb begin
    res_o.inv00    = inv[0];
    res_o.inv01    = inv[1];
    res_o.inv02    = inv[2];
    res_o.inv10    = inv[3];
    res_o.inv11    = inv[4];
    res_o.inv12    = inv[5];
    res_o.inv20    = inv[6];
    res_o.inv21    = inv[7];
    res_o.inv22    = inv[8];
    res_o.singular = sing_q[QB];
    res_o.overflow = !sing_q[QB] && (ovf != '0);
  end

  assign vld_o = vld_q[QB];

endmodule

FILE: rtl/core/matrix3_inverse.sv
// Top level of the pipelined 3x3 fixed-point matrix inverse.
//
//  channel  dir  payload                        transaction
//  in_i     in   a00..a22, signed Q(32-F).F     one matrix
//  out_o    out  inv00..inv22, singular, overflow  one inverse
//
//  Rate: one transaction per cycle in each direction while the skid register is empty;
//  a result reaches out_o through 41 register stages (2 cofactor,
//  3 determinant, 2 magnitude and range check, 33 divider steps, 1 output register).
//  The 33 one-bit restoring steps of the nine-lane divider set the depth.
//  Reset clears every valid bit and the output and skid registers' flags.
//  Stalls: the whole pipeline freezes while the skid register is full, so
//  in_i.ready is a register output and never waits on out_o.ready.
module matrix3_inverse
  import mi3_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mi3_in_if.sink    in_i,
  mi3_out_if.source out_o
);

  logic                 en;
  logic                 cof_vld, det_vld, div_vld;
  logic signed [EW-1:0] row0 [3];
  logic signed [CW-1:0] cof_c [9];
  logic signed [CW-1:0] cof_d [9];
  logic signed [DW-1:0] det;
  out_t                 res;

  logic out_v_q, skid_v_q;
  out_t out_q, skid_q;
  logic take;

  // advance every stage unless the skid register holds a result
  assign en         = !skid_v_q;
  assign in_i.ready = en;

  mi3_cof u_cof (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_i.valid),
    .mat_i  (in_i.data),
    .vld_o  (cof_vld),
    .row0_o (row0),
    .cof_o  (cof_c)
  );

  mi3_det u_det (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (cof_vld),
    .row0_i (row0),
    .cof_i  (cof_c),
    .vld_o  (det_vld),
    .det_o  (det),
    .cof_o  (cof_d)
  );

  mi3_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (det_vld),
    .det_i  (det),
    .cof_i  (cof_d),
    .vld_o  (div_vld),
    .res_o  (res)
  );

  assign take = out_v_q && out_o.ready;

  // output register with a one-entry skid behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (skid_v_q) begin
      if (take) begin
        skid_v_q <= 1'b0;
      end
    end else if (div_vld) begin
      if (!out_v_q || take) begin
        out_v_q <= 1'b1;
      end else begin
        skid_v_q <= 1'b1;
      end
    end else if (take) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_v_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (div_vld) begin
      if (!out_v_q || take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

endmodule
